### sv/bpms_pkg.sv
`timescale 1ns / 1ps
package bpms_pkg;

   localparam int unsigned CFG_W = 11;
   localparam int unsigned COORD_W = 11;
   localparam int unsigned SIZE_W = 12;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FILL  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // One classified command handed from the front end to the executor.
   typedef struct packed {
      logic                  reject;
      action_type            action;
      logic [COORD_W-1:0]    x0;
      logic [COORD_W-1:0]    y0;
      logic [SIZE_W-1:0]     rw;
      logic [SIZE_W-1:0]     rh;
      logic                  value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_MEM,
      ST_WRITE,
      ST_NEXT,
      ST_RESP
   } state_type;

endpackage

### sv/bpms_front.sv
`timescale 1ns / 1ps
module bpms_front #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [bpms_pkg::CFG_W-1:0]        csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [bpms_pkg::COORD_W-1:0]      req_x_pos,
   input  logic [bpms_pkg::COORD_W-1:0]      req_y_pos,
   input  logic [bpms_pkg::SIZE_W-1:0]       req_rect_width,
   input  logic [bpms_pkg::SIZE_W-1:0]       req_rect_height,
   input  logic                              req_pixel_value,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output bpms_pkg::cmd_type                 cmd,
   output logic [13:0]                       eff_width
);

   localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
   localparam logic [13:0] MAXH = 14'(MAX_HEIGHT);

   logic [bpms_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [13:0] ew, eh, xe, ye;
   logic        in_bounds, fits;
   bpms_pkg::cmd_type c_in;
   // Two-entry queue between classification and execution.
   bpms_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   logic       push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         height_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == bpms_pkg::CSR_WIDTH) width_ff <= csr_write_data;
         else height_ff <= csr_write_data;
      end
   end

   always_comb begin
      ew = (14'(width_ff) > MAXW) ? MAXW : 14'(width_ff);
      eh = (14'(height_ff) > MAXH) ? MAXH : 14'(height_ff);
      xe = 14'(req_x_pos) + 14'(req_rect_width);
      ye = 14'(req_y_pos) + 14'(req_rect_height);
      in_bounds = (14'(req_x_pos) < ew) && (14'(req_y_pos) < eh);
      fits = (xe <= ew) && (ye <= eh);
      c_in.action = bpms_pkg::action_type'(req_action);
      c_in.x0 = req_x_pos;
      c_in.y0 = req_y_pos;
      c_in.rw = req_rect_width;
      c_in.rh = req_rect_height;
      c_in.value = req_pixel_value;
      case (c_in.action)
         bpms_pkg::ACT_READ, bpms_pkg::ACT_WRITE: c_in.reject = !in_bounds;
         bpms_pkg::ACT_FILL: c_in.reject = !(in_bounds && fits);
         default: c_in.reject = 1'b1;
      endcase
   end

   assign eff_width = ew;
   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= c_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### sv/bpms_exec.sv
`timescale 1ns / 1ps
module bpms_exec #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  bpms_pkg::cmd_type      cmd,
   input  logic [13:0]            eff_width,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_status,
   output logic                   rsp_read_bit
);

   localparam int unsigned BYTES = (MAX_WIDTH * MAX_HEIGHT + 7) / 8;
   localparam int unsigned AW = (BYTES > 1) ? $clog2(BYTES) : 1;
   localparam int unsigned PW = 27;

   logic [7:0] mem [BYTES];
   logic [7:0] rdata_ff;

   bpms_pkg::state_type state_ff, state_in;
   bpms_pkg::cmd_type cmd_ff, cmd_in;
   logic [bpms_pkg::SIZE_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [AW-1:0] addr;
   logic [PW-1:0] byte_idx;
   logic [7:0] bitmask, wdata;
   logic       mem_we;
   logic       status_ff, status_in;
   logic [PW-1:0] prod;

   // Byte index clamps to the last byte, as a position past the store does.
   assign byte_idx = pos_ff >> 3;
   assign addr = (byte_idx >= PW'(BYTES)) ? AW'(BYTES - 1) : byte_idx[AW-1:0];
   assign bitmask = 8'd1 << pos_ff[2:0];
   assign wdata = cmd_ff.value ? (rdata_ff | bitmask) : (rdata_ff & ~bitmask);
   assign prod = PW'(14'(cmd_ff.y0) + 14'(j_ff)) * PW'(eff_width)
      + PW'(cmd_ff.x0) + PW'(i_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      i_ff <= i_in;
      j_ff <= j_in;
      pos_ff <= pos_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      i_in = i_ff;
      j_in = j_ff;
      pos_in = pos_ff;
      status_in = status_ff;
      cmd_ready = 1'b0;
      mem_we = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bpms_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               i_in = '0;
               j_in = '0;
               status_in = cmd.reject;
               if (cmd.reject) state_in = bpms_pkg::ST_RESP;
               else if (cmd.action == bpms_pkg::ACT_FILL &&
                        (cmd.rw == '0 || cmd.rh == '0)) state_in = bpms_pkg::ST_RESP;
               else state_in = bpms_pkg::ST_ADDR;
            end
         end
         bpms_pkg::ST_ADDR: begin
            pos_in = prod;
            state_in = bpms_pkg::ST_MEM;
         end
         bpms_pkg::ST_MEM: begin
            state_in = (cmd_ff.action == bpms_pkg::ACT_READ) ? bpms_pkg::ST_RESP
                                                             : bpms_pkg::ST_WRITE;
         end
         bpms_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            state_in = bpms_pkg::ST_NEXT;
            if (cmd_ff.action == bpms_pkg::ACT_WRITE) state_in = bpms_pkg::ST_RESP;
         end
         bpms_pkg::ST_NEXT: begin
            state_in = bpms_pkg::ST_ADDR;
            if (i_ff + 1'b1 < cmd_ff.rw) begin
               i_in = i_ff + 1'b1;
            end else begin
               i_in = '0;
               j_in = j_ff + 1'b1;
               if (j_ff + 1'b1 >= cmd_ff.rh) state_in = bpms_pkg::ST_RESP;
            end
         end
         bpms_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = bpms_pkg::ST_IDLE;
         end
         default: state_in = bpms_pkg::ST_IDLE;
      endcase
   end

   assign rsp_status = status_ff;
   assign rsp_read_bit = (cmd_ff.action == bpms_pkg::ACT_READ && !cmd_ff.reject)
      ? rdata_ff[pos_ff[2:0]] : 1'b0;

endmodule

### sv/bit_packed_mask_store_unit.sv
`timescale 1ns / 1ps
// One-bit-per-pixel mask store with pixel read, pixel write and rectangle fill over
// a byte-wide single-port memory. A front end classifies each request against the
// configured size and queues up to two; the executor works one at a time. A fill
// does a read-modify-write of one byte per pixel.
module bit_packed_mask_store_unit #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [bpms_pkg::CFG_W-1:0]   csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic [bpms_pkg::COORD_W-1:0] req_x_pos,
   input  logic [bpms_pkg::COORD_W-1:0] req_y_pos,
   input  logic [bpms_pkg::SIZE_W-1:0]  req_rect_width,
   input  logic [bpms_pkg::SIZE_W-1:0]  req_rect_height,
   input  logic                         req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic                         rsp_read_bit
);

   logic              cmd_valid, cmd_ready;
   bpms_pkg::cmd_type cmd;
   logic [13:0]       eff_width;

   bpms_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req_valid, .req_ready, .req_action, .req_x_pos, .req_y_pos,
      .req_rect_width, .req_rect_height, .req_pixel_value,
      .cmd_valid, .cmd_ready, .cmd, .eff_width
   );

   bpms_exec #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_exec (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .eff_width,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_read_bit
   );

endmodule

### tb/bit_packed_mask_store_unit_test.sv
`timescale 1ns / 1ps
module bit_packed_mask_store_unit_test;

   localparam int unsigned PIXELS = 1024 * 1024;
   localparam int unsigned EFF_MAX = 1024;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef logic [bpms_pkg::COORD_W-1:0] coord_type;
   typedef logic [bpms_pkg::SIZE_W-1:0]  size_type;

   typedef struct {
      logic [1:0] act;
      coord_type  x;
      coord_type  y;
      size_type   rw;
      size_type   rh;
      logic       v;
   } request_type;

   typedef struct {
      logic status;
      logic read_bit;
   } outcome_type;

   class mask_scoreboard_type;
      int unsigned cfg_w;
      int unsigned cfg_h;
      bit          pix[PIXELS];
      bit          seen[PIXELS];
      outcome_type pending[$];
      int unsigned recent[$];
      int          errors;

      function new();
         cfg_w = 0;
         cfg_h = 0;
         errors = 0;
      endfunction

      function int unsigned eff_w();
         return (cfg_w > EFF_MAX) ? EFF_MAX : cfg_w;
      endfunction

      function int unsigned eff_h();
         return (cfg_h > EFF_MAX) ? EFF_MAX : cfg_h;
      endfunction

      function void store_pixel(int unsigned pos, bit v);
         pix[pos] = v;
         if (!seen[pos]) begin
            seen[pos] = 1'b1;
            recent.push_back(pos);
            if (recent.size() > 256) void'(recent.pop_front());
         end
      endfunction

      function void note_request(request_type r);
         int unsigned w, h, x, y, rw, rh;
         bit in_bounds;
         outcome_type o;
         w = eff_w();
         h = eff_h();
         x = 32'(r.x);
         y = 32'(r.y);
         rw = 32'(r.rw);
         rh = 32'(r.rh);
         in_bounds = (x < w) && (y < h);
         o.status = 1'b1;
         o.read_bit = 1'b0;
         case (bpms_pkg::action_type'(r.act))
            bpms_pkg::ACT_READ: begin
               if (in_bounds) begin
                  o.read_bit = pix[y * w + x];
                  o.status = 1'b0;
               end
            end
            bpms_pkg::ACT_WRITE: begin
               if (in_bounds) begin
                  store_pixel(y * w + x, r.v);
                  o.status = 1'b0;
               end
            end
            bpms_pkg::ACT_FILL: begin
               if (in_bounds && x + rw <= w && y + rh <= h) begin
                  for (int unsigned j = 0; j < rh; j++)
                     for (int unsigned i = 0; i < rw; i++)
                        store_pixel((y + j) * w + x + i, r.v);
                  o.status = 1'b0;
               end
            end
            default: ;
         endcase
         pending.push_back(o);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_response(logic status, logic read_bit);
         outcome_type o;
         if (pending.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            o = pending.pop_front();
            if (status !== o.status)
               report($sformatf("status %b, predicted %b", status, o.status));
            if (read_bit !== o.read_bit)
               report($sformatf("read_bit %b, predicted %b", read_bit, o.read_bit));
         end
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic                          csr_index = bpms_pkg::CSR_WIDTH;
   logic [bpms_pkg::CFG_W-1:0]    csr_write_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_action = bpms_pkg::ACT_READ;
   coord_type                     req_x_pos = '0;
   coord_type                     req_y_pos = '0;
   size_type                      req_rect_width = '0;
   size_type                      req_rect_height = '0;
   logic                          req_pixel_value = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_status;
   logic                          rsp_read_bit;

   mask_scoreboard_type sb;
   longint cycles = 0;
   bit     hold_request = 1'b0;
   bit     sender_busy_idle = 1'b1;
   bit     receiver_idle = 1'b1;

   bit_packed_mask_store_unit u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_x_pos(req_x_pos),
      .req_y_pos(req_y_pos),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_read_bit(rsp_read_bit)
   );

   always #4 clock = ~clock;

   initial sb = new();

   always @(posedge clock) begin
      request_type r;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && sb != null) begin
         if (req_valid && req_ready) begin
            r.act = req_action;
            r.x = req_x_pos;
            r.y = req_y_pos;
            r.rw = req_rect_width;
            r.rh = req_rect_height;
            r.v = req_pixel_value;
            sb.note_request(r);
         end
         if (rsp_valid && rsp_ready) sb.check_response(rsp_status, rsp_read_bit);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // The receiver; a long hold-off is requested by the sender and counted here.
   initial begin
      int stall;
      int hold;
      stall = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (receiver_idle) stall = gap_len();
         end
      end
   end

   task automatic write_reg(logic idx, logic [bpms_pkg::CFG_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == bpms_pkg::CSR_WIDTH) sb.cfg_w = 32'(val);
      else sb.cfg_h = 32'(val);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h);
      drain();
      write_reg(bpms_pkg::CSR_WIDTH, w[bpms_pkg::CFG_W-1:0]);
      write_reg(bpms_pkg::CSR_HEIGHT, h[bpms_pkg::CFG_W-1:0]);
   endtask

   task automatic send_request(request_type r);
      int g;
      g = sender_busy_idle ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.act;
      req_x_pos <= r.x;
      req_y_pos <= r.y;
      req_rect_width <= r.rw;
      req_rect_height <= r.rh;
      req_pixel_value <= r.v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_fields(bpms_pkg::action_type a, int unsigned x, int unsigned y,
                              int unsigned rw, int unsigned rh, bit v);
      request_type r;
      r.act = a;
      r.x = coord_type'(x);
      r.y = coord_type'(y);
      r.rw = size_type'(rw);
      r.rh = size_type'(rh);
      r.v = v;
      send_request(r);
   endtask

   // The last request was accepted at the edge just passed.
   task automatic finish_sending();
      req_valid <= 1'b0;
   endtask

   // Builds one random request against the current image size: mostly legal
   // writes, reads of written pixels and small fills, the rest noise.
   function automatic request_type random_request();
      request_type r;
      int unsigned w, h, sel, pos, rw, rh;
      w = sb.eff_w();
      h = sb.eff_h();
      sel = $urandom_range(0, 99);
      r.act = bpms_pkg::ACT_WRITE;
      r.x = coord_type'($urandom);
      r.y = coord_type'($urandom);
      r.rw = size_type'($urandom);
      r.rh = size_type'($urandom);
      r.v = 1'($urandom);
      if (w == 0 || h == 0 || sel >= 80) begin
         // Noise: out-of-range coordinates, unknown action or oversized fills.
         case ($urandom_range(0, 3))
            0: r.act = bpms_pkg::ACT_NONE;
            1: r.act = bpms_pkg::ACT_FILL;
            2: begin
               r.act = bpms_pkg::ACT_READ;
               if (r.x < w && r.y < h) r.x = coord_type'(w + $urandom_range(0, 2047 - w));
            end
            default: r.act = bpms_pkg::ACT_WRITE;
         endcase
         if (r.act == bpms_pkg::ACT_FILL && r.x < w && r.y < h && r.x + r.rw <= w
             && r.y + r.rh <= h && r.rw * r.rh > 64)
            r.rw = size_type'(w + 1);
         if (r.act == bpms_pkg::ACT_WRITE && (r.x < w && r.y < h))
            r.y = coord_type'(h + $urandom_range(0, 2047 - h));
         return r;
      end
      r.x = coord_type'($urandom_range(0, w - 1));
      r.y = coord_type'($urandom_range(0, h - 1));
      if (sel < 40) begin
         r.act = bpms_pkg::ACT_WRITE;
      end else if (sel < 65) begin
         r.act = bpms_pkg::ACT_READ;
         if (!sb.seen[r.y * w + r.x] && sb.recent.size() != 0) begin
            pos = sb.recent[$urandom_range(0, sb.recent.size() - 1)];
            if (pos / w < h) begin
               r.x = coord_type'(pos % w);
               r.y = coord_type'(pos / w);
            end
         end
         if (!sb.seen[r.y * w + r.x]) r.act = bpms_pkg::ACT_WRITE;
      end else begin
         r.act = bpms_pkg::ACT_FILL;
         rw = $urandom_range(0, 8);
         rh = $urandom_range(0, 8);
         if (rw > w) rw = w;
         if (rh > h) rh = h;
         r.x = coord_type'($urandom_range(0, w - (rw == 0 ? 1 : rw)));
         r.y = coord_type'($urandom_range(0, h - (rh == 0 ? 1 : rh)));
         r.rw = size_type'(rw);
         r.rh = size_type'(rh);
      end
      return r;
   endfunction

   task automatic random_phase(int n, bit with_hold);
      for (int i = 0; i < n; i++) begin
         if (with_hold && i == n / 3) hold_request = 1'b1;
         if (with_hold && i == (2 * n) / 3) begin
            req_valid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         send_request(random_request());
      end
      finish_sending();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Empty image straight after reset rejects everything.
      send_fields(bpms_pkg::ACT_READ, 0, 0, 0, 0, 0);
      send_fields(bpms_pkg::ACT_WRITE, 0, 0, 0, 0, 1);
      send_fields(bpms_pkg::ACT_NONE, 2047, 2047, 4095, 4095, 1);
      finish_sending();

      configure(8, 8);
      send_fields(bpms_pkg::ACT_WRITE, 0, 0, 0, 0, 1);
      send_fields(bpms_pkg::ACT_WRITE, 7, 7, 0, 0, 1);
      send_fields(bpms_pkg::ACT_READ, 0, 0, 0, 0, 0);
      send_fields(bpms_pkg::ACT_READ, 7, 7, 0, 0, 0);
      send_fields(bpms_pkg::ACT_READ, 8, 0, 0, 0, 0);
      send_fields(bpms_pkg::ACT_WRITE, 0, 8, 0, 0, 1);
      send_fields(bpms_pkg::ACT_FILL, 0, 0, 8, 8, 1);
      send_fields(bpms_pkg::ACT_READ, 3, 4, 0, 0, 0);
      send_fields(bpms_pkg::ACT_FILL, 3, 3, 0, 4, 0);
      send_fields(bpms_pkg::ACT_FILL, 3, 3, 4, 0, 0);
      send_fields(bpms_pkg::ACT_FILL, 8, 0, 0, 0, 0);
      send_fields(bpms_pkg::ACT_FILL, 4, 0, 5, 1, 0);
      send_fields(bpms_pkg::ACT_FILL, 0, 0, 2048, 2048, 0);
      send_fields(bpms_pkg::ACT_FILL, 2, 2, 3, 3, 0);
      send_fields(bpms_pkg::ACT_READ, 3, 3, 0, 0, 0);
      send_fields(bpms_pkg::ACT_WRITE, 7, 7, 0, 0, 0);
      send_fields(bpms_pkg::ACT_READ, 7, 7, 0, 0, 0);
      send_fields(bpms_pkg::ACT_READ, 2047, 2047, 0, 0, 0);
      send_fields(bpms_pkg::ACT_NONE, 1, 1, 1, 1, 0);
      finish_sending();

      configure(0, 5);
      random_phase(30, 0);
      configure(5, 0);
      random_phase(20, 0);
      configure(1024, 1024);
      random_phase(220, 1);
      configure(2047, 2047);
      random_phase(150, 0);
      configure(1, 1);
      sender_busy_idle = 1'b0;
      receiver_idle = 1'b0;
      random_phase(80, 0);
      sender_busy_idle = 1'b1;
      receiver_idle = 1'b1;
      configure(13, 1024);
      random_phase(120, 0);
      for (int k = 0; k < 3; k++) begin
         configure($urandom_range(1, 64), $urandom_range(1, 64));
         random_phase(145, k == 1);
      end

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
